FILE: rtl/ccfd_pkg.sv
package ccfd_pkg;

    localparam logic [7:0]  CRC8_POLY  = 8'h8C;
    localparam logic [15:0] CRC16_POLY = 16'h8408;

    localparam logic [7:0]  START_BYTE_RST  = 8'hA5;
    localparam logic [5:0]  LENGTH_LIM_RST  = 6'd32;
    localparam logic [7:0]  HDR_SEED_RST    = 8'hFF;
    localparam logic [15:0] FRAME_SEED_RST  = 16'hFFFF;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_LIM = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HDR_SEED   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_SEED = 2'd3;

    typedef enum logic [2:0] {
        ST_PAYLOAD    = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_LEN_REJECT = 3'd2,
        ST_HCRC_BAD   = 3'd3,
        ST_FCRC_BAD   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_START   = 3'd1,
        OP_HEADER  = 3'd2,
        OP_COMMAND = 3'd3,
        OP_PAYLOAD = 3'd4,
        OP_TAIL    = 3'd5
    } op_t;

    // controller -> datapath
    typedef struct packed {
        op_t     op;
        logic    rd_issue;
        logic    idx_step;
        logic    out_load;
        status_t out_kind;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       sof;
        logic [4:0] count;
        logic       len_bad;
        logic       hcrc_ok;
        logic       pay_done;
        logic       len_zero;
        logic       fcrc_ok;
        logic       run_last;
        logic       out_free;
    } sts_t;

endpackage

FILE: rtl/ccfd_ram.sv
module ccfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ccfd_ctrl.sv
module ccfd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rx_valid,
    output logic          rx_ready,
    input  ccfd_pkg::sts_t sts,
    output ccfd_pkg::cmd_t cmd
);

    import ccfd_pkg::*;

    typedef enum logic [6:0] {
        S_HUNT    = 7'b0000001,
        S_HEADER  = 7'b0000010,
        S_COMMAND = 7'b0000100,
        S_PAYLOAD = 7'b0001000,
        S_TAIL    = 7'b0010000,
        S_READ    = 7'b0100000,
        S_EMIT    = 7'b1000000
    } state_t;

    state_t  state_reg, state_next;
    status_t kind_reg, kind_next;
    logic    accept;

    assign rx_ready = (state_reg == S_HUNT) || (state_reg == S_HEADER) ||
                      (state_reg == S_COMMAND) || (state_reg == S_PAYLOAD) ||
                      (state_reg == S_TAIL);
    assign accept   = rx_valid && rx_ready;

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cmd.op       = OP_NONE;
        cmd.rd_issue = 1'b0;
        cmd.idx_step = 1'b0;
        cmd.out_load = 1'b0;
        cmd.out_kind = kind_reg;
        case (state_reg)
            S_HEADER:
            begin
                if (accept)
                begin
                    cmd.op = OP_HEADER;
                    if (sts.count == 5'd1 && sts.len_bad)
                    begin
                        kind_next  = ST_LEN_REJECT;
                        state_next = S_EMIT;
                    end
                    else if (sts.count == 5'd3)
                    begin
                        if (sts.hcrc_ok)
                        begin
                            state_next = S_COMMAND;
                        end
                        else
                        begin
                            kind_next  = ST_HCRC_BAD;
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_COMMAND:
            begin
                if (accept)
                begin
                    cmd.op = OP_COMMAND;
                    if (sts.count == 5'd1)
                    begin
                        state_next = sts.len_zero ? S_TAIL : S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD:
            begin
                if (accept)
                begin
                    cmd.op = OP_PAYLOAD;
                    if (sts.pay_done)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                if (accept)
                begin
                    cmd.op = OP_TAIL;
                    if (sts.count == 5'd1)
                    begin
                        if (!sts.fcrc_ok)
                        begin
                            kind_next  = ST_FCRC_BAD;
                            state_next = S_EMIT;
                        end
                        else if (sts.len_zero)
                        begin
                            kind_next  = ST_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            kind_next  = ST_PAYLOAD;
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (kind_reg == ST_PAYLOAD && !sts.run_last)
                    begin
                        cmd.idx_step = 1'b1;
                        state_next   = S_READ;
                    end
                    else
                    begin
                        state_next = S_HUNT;
                    end
                end
            end
            default:
            begin
                state_next = S_HUNT;
                if (accept && sts.sof)
                begin
                    cmd.op     = OP_START;
                    state_next = S_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
            kind_reg  <= ST_PAYLOAD;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

FILE: rtl/ccfd_datapath.sv
module ccfd_datapath #(
    parameter int PAYLOAD_DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ccfd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ccfd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [7:0]                            rx_byte,
    input  ccfd_pkg::cmd_t                        cmd,
    output ccfd_pkg::sts_t                        sts,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic [2:0]                            status,
    output logic [15:0]                           command_id,
    output logic [7:0]                            sequence_res,
    output logic [4:0]                            payload_length,
    output logic [7:0]                            payload_byte,
    output logic [4:0]                            byte_index,
    output logic                                  last
);

    import ccfd_pkg::*;

    // payload never exceeds 31 bytes, so at most 32 entries are ever used
    localparam int         STORE_DEPTH = (PAYLOAD_DEPTH < 32) ? PAYLOAD_DEPTH : 32;
    localparam int         AW          = $clog2(STORE_DEPTH);
    localparam logic [7:0] LEN_CAP     = 8'(STORE_DEPTH);

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // configuration
    logic [7:0]  start_byte_reg;
    logic [5:0]  length_limit_reg;
    logic [7:0]  hdr_seed_reg;
    logic [15:0] frame_seed_reg;

    // frame state
    logic [4:0]  count_reg, count_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] cmd_id_reg, cmd_id_next;
    logic [7:0]  hcrc_reg, hcrc_next;
    logic [15:0] fcrc_reg, fcrc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [4:0]  idx_reg, idx_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] command_id_reg, command_id_next;
    logic [7:0]  sequence_reg, sequence_next;
    logic [4:0]  length_reg, length_out_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [4:0]  index_reg, index_next;
    logic        last_reg, last_next;

    logic [7:0]  ram_rdata;
    logic        ram_we;

    assign ram_we = (cmd.op == OP_PAYLOAD);

    ccfd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.sof      = (rx_byte == start_byte_reg);
        sts.count    = count_reg;
        sts.len_bad  = (rx_byte != 8'h00) || (len_reg >= {2'b00, length_limit_reg}) ||
                       (len_reg >= LEN_CAP);
        sts.hcrc_ok  = (rx_byte == hcrc_reg);
        sts.pay_done = ({3'b000, count_reg} + 8'd1) >= len_reg;
        sts.len_zero = (len_reg == 8'h00);
        sts.fcrc_ok  = (crc_lo_reg == fcrc_reg[7:0]) && (rx_byte == fcrc_reg[15:8]);
        sts.run_last = ({3'b000, idx_reg} + 8'd1) == len_reg;
        sts.out_free = !out_valid_reg || res_ready;
    end

    always_comb
    begin
        count_next  = count_reg;
        len_next    = len_reg;
        seq_next    = seq_reg;
        cmd_id_next = cmd_id_reg;
        hcrc_next   = hcrc_reg;
        fcrc_next   = fcrc_reg;
        crc_lo_next = crc_lo_reg;
        idx_next    = idx_reg;
        case (cmd.op)
            OP_START:
            begin
                hcrc_next   = crc8_byte(hdr_seed_reg, rx_byte);
                fcrc_next   = crc16_byte(frame_seed_reg, rx_byte);
                len_next    = 8'h00;
                seq_next    = 8'h00;
                cmd_id_next = 16'h0000;
                count_next  = 5'd0;
            end
            OP_HEADER:
            begin
                // CRC8 covers start byte, length and sequence, not its own byte
                if (count_reg != 5'd3)
                begin
                    hcrc_next = crc8_byte(hcrc_reg, rx_byte);
                end
                fcrc_next = crc16_byte(fcrc_reg, rx_byte);
                if (count_reg == 5'd0)
                begin
                    len_next = rx_byte;
                end
                if (count_reg == 5'd2)
                begin
                    seq_next = rx_byte;
                end
                count_next = (count_reg == 5'd3) ? 5'd0 : count_reg + 5'd1;
            end
            OP_COMMAND:
            begin
                fcrc_next = crc16_byte(fcrc_reg, rx_byte);
                if (count_reg == 5'd0)
                begin
                    cmd_id_next = {8'h00, rx_byte};
                    count_next  = 5'd1;
                end
                else
                begin
                    cmd_id_next = {rx_byte, cmd_id_reg[7:0]};
                    count_next  = 5'd0;
                end
            end
            OP_PAYLOAD:
            begin
                fcrc_next  = crc16_byte(fcrc_reg, rx_byte);
                count_next = sts.pay_done ? 5'd0 : count_reg + 5'd1;
            end
            OP_TAIL:
            begin
                crc_lo_next = rx_byte;
                count_next  = 5'd1;
                idx_next    = 5'd0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (cmd.idx_step)
        begin
            idx_next = idx_reg + 5'd1;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !res_ready;
        status_next     = status_reg;
        command_id_next = command_id_reg;
        sequence_next   = sequence_reg;
        length_out_next = length_reg;
        pbyte_next      = pbyte_reg;
        index_next      = index_reg;
        last_next       = last_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            status_next     = cmd.out_kind;
            command_id_next = cmd_id_reg;
            sequence_next   = seq_reg;
            length_out_next = len_reg[4:0];
            pbyte_next      = 8'h00;
            index_next      = 5'd0;
            last_next       = 1'b1;
            case (cmd.out_kind)
                ST_PAYLOAD:
                begin
                    pbyte_next = ram_rdata;
                    index_next = idx_reg;
                    last_next  = sts.run_last;
                end
                ST_LEN_REJECT:
                begin
                    command_id_next = 16'h0000;
                    sequence_next   = 8'h00;
                    length_out_next = 5'd0;
                end
                ST_HCRC_BAD:
                begin
                    command_id_next = 16'h0000;
                end
                default:
                begin
                    last_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= START_BYTE_RST;
            length_limit_reg <= LENGTH_LIM_RST;
            hdr_seed_reg     <= HDR_SEED_RST;
            frame_seed_reg   <= FRAME_SEED_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_BYTE: start_byte_reg   <= cfg_data[7:0];
                    CFG_LENGTH_LIM: length_limit_reg <= cfg_data[5:0];
                    CFG_HDR_SEED:   hdr_seed_reg     <= cfg_data[7:0];
                    CFG_FRAME_SEED: frame_seed_reg   <= cfg_data[15:0];
                    default:        start_byte_reg   <= start_byte_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg      <= count_next;
        len_reg        <= len_next;
        seq_reg        <= seq_next;
        cmd_id_reg     <= cmd_id_next;
        hcrc_reg       <= hcrc_next;
        fcrc_reg       <= fcrc_next;
        crc_lo_reg     <= crc_lo_next;
        idx_reg        <= idx_next;
        status_reg     <= status_next;
        command_id_reg <= command_id_next;
        sequence_reg   <= sequence_next;
        length_reg     <= length_out_next;
        pbyte_reg      <= pbyte_next;
        index_reg      <= index_next;
        last_reg       <= last_next;
    end

    assign res_valid      = out_valid_reg;
    assign status         = status_reg;
    assign command_id     = command_id_reg;
    assign sequence_res   = sequence_reg;
    assign payload_length = length_reg;
    assign payload_byte   = pbyte_reg;
    assign byte_index     = index_reg;
    assign last           = last_reg;

endmodule

FILE: rtl/crc_checked_frame_deframer.sv
// Frame deframer: hunts for the start byte, then takes a 2-byte little-endian
// length, a sequence byte, a CRC8 over those (reflected 0x31, seeded), a 2-byte
// command id, the payload and a CRC16 (reflected 0x1021, seeded) sent low byte
// first. Received bytes are taken one per cycle while a frame is parsed; the
// payload goes into a small buffer RAM. A good frame then drains its N payload
// bytes as one result each (a buffer read, then a load of the output register
// that waits while the output side stalls); an empty frame or a failure gives
// one result, loaded once the output register is free. No bytes are taken
// while results are drained. Failed bytes are not rescanned for a start byte.
module crc_checked_frame_deframer #(
    parameter int PAYLOAD_DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ccfd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ccfd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  rx_valid,
    output logic                                  rx_ready,
    input  logic [7:0]                            rx_byte,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic [2:0]                            status,
    output logic [15:0]                           command_id,
    output logic [7:0]                            sequence_res,
    output logic [4:0]                            payload_length,
    output logic [7:0]                            payload_byte,
    output logic [4:0]                            byte_index,
    output logic                                  last
);

    import ccfd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ccfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ccfd_datapath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .sts            (sts),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .status         (status),
        .command_id     (command_id),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

endmodule

FILE: sim/tb_crc_checked_frame_deframer.sv
module tb_crc_checked_frame_deframer;

    import ccfd_pkg::*;

    localparam int BUF_DEPTH   = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 20;
    localparam int PHASE_BYTES = 60;
    localparam int HOLD_CYCLES = 400;

    localparam logic [7:0]  CRC8_REFL  = 8'h8C;
    localparam logic [15:0] CRC16_REFL = 16'h8408;

    typedef enum logic [2:0] {
        P_HUNT,
        P_HDR,
        P_CMD,
        P_PAY,
        P_TAIL
    } parse_phase_t;

    typedef enum logic [1:0] {
        FR_GOOD,
        FR_HDR_BAD,
        FR_FCS_BAD,
        FR_LEN_BAD
    } frame_kind_t;

    typedef struct {
        status_t     st;
        logic [15:0] cmd;
        logic [7:0]  seq;
        logic [4:0]  len;
        logic [7:0]  data;
        logic [4:0]  idx;
        logic        lst;
    } frame_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_START_BYTE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   rx_valid  = 1'b0;
    logic                   rx_ready;
    logic [7:0]             rx_byte   = 8'h00;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [2:0]             status;
    logic [15:0]            command_id;
    logic [7:0]             sequence_res;
    logic [4:0]             payload_length;
    logic [7:0]             payload_byte;
    logic [4:0]             byte_index;
    logic                   last;

    crc_checked_frame_deframer #(
        .PAYLOAD_DEPTH (BUF_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .status         (status),
        .command_id     (command_id),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

    always #5 clk = ~clk;

    // register shadow
    logic [7:0]  cfg_start     = START_BYTE_RST;
    logic [5:0]  cfg_limit     = LENGTH_LIM_RST;
    logic [7:0]  cfg_hdr_seed  = HDR_SEED_RST;
    logic [15:0] cfg_frame_seed = FRAME_SEED_RST;

    // deframer shadow state
    parse_phase_t pr_phase = P_HUNT;
    logic [5:0]   pr_count = '0;
    logic [15:0]  pr_len   = '0;
    logic [7:0]   pr_seq   = '0;
    logic [15:0]  pr_cmd   = '0;
    logic [7:0]   pr_hcrc  = HDR_SEED_RST;
    logic [15:0]  pr_fcrc  = FRAME_SEED_RST;
    logic [7:0]   pr_crc_lo = '0;
    logic [7:0]   pr_store [BUF_DEPTH];

    logic [7:0]    rx_backlog [$];
    frame_result_t predicted_results [$];
    frame_result_t seen_want;

    int   queued_bytes = 0;
    int   err_count    = 0;
    int   stall_req    = 0;
    int   stall_ack    = 0;
    int   stall_left   = 0;
    int   cycle_count  = 0;
    bit   steady_flow  = 1'b0;

    logic [7:0]  gen_hcrc;
    logic [15:0] gen_fcrc;

    function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC8_REFL) : (c >> 1);
        return c;
    endfunction

    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC16_REFL) : (c >> 1);
        return c;
    endfunction

    function automatic void queue_result(status_t st, logic [15:0] cmd, logic [7:0] seq,
                                         logic [4:0] len, logic [7:0] data,
                                         logic [4:0] idx, logic lst);
        frame_result_t r;
        r.st   = st;
        r.cmd  = cmd;
        r.seq  = seq;
        r.len  = len;
        r.data = data;
        r.idx  = idx;
        r.lst  = lst;
        predicted_results.push_back(r);
    endfunction

    function automatic void deframe_step(logic [7:0] b);
        case (pr_phase)
            P_HDR:
            begin
                if (pr_count < 3)
                    pr_hcrc = crc8_next(pr_hcrc, b);
                pr_fcrc = crc16_next(pr_fcrc, b);
                if (pr_count == 0)
                begin
                    pr_len   = {8'h00, b};
                    pr_count = 1;
                end
                else if (pr_count == 1)
                begin
                    pr_len[15:8] = b;
                    if (pr_len >= cfg_limit || pr_len >= 32 || pr_len >= BUF_DEPTH)
                    begin
                        queue_result(ST_LEN_REJECT, '0, '0, '0, '0, '0, 1'b1);
                        pr_phase = P_HUNT;
                    end
                    else
                    begin
                        pr_count = 2;
                    end
                end
                else if (pr_count == 2)
                begin
                    pr_seq   = b;
                    pr_count = 3;
                end
                else if (b != pr_hcrc)
                begin
                    queue_result(ST_HCRC_BAD, '0, pr_seq, pr_len[4:0], '0, '0, 1'b1);
                    pr_phase = P_HUNT;
                end
                else
                begin
                    pr_phase = P_CMD;
                    pr_count = 0;
                end
            end
            P_CMD:
            begin
                pr_fcrc = crc16_next(pr_fcrc, b);
                if (pr_count == 0)
                begin
                    pr_cmd   = {8'h00, b};
                    pr_count = 1;
                end
                else
                begin
                    pr_cmd[15:8] = b;
                    pr_count     = 0;
                    pr_phase     = (pr_len == 0) ? P_TAIL : P_PAY;
                end
            end
            P_PAY:
            begin
                pr_fcrc = crc16_next(pr_fcrc, b);
                pr_store[pr_count % BUF_DEPTH] = b;
                pr_count = pr_count + 6'd1;
                if (pr_count >= pr_len)
                begin
                    pr_count = 0;
                    pr_phase = P_TAIL;
                end
            end
            P_TAIL:
            begin
                if (pr_count == 0)
                begin
                    pr_crc_lo = b;
                    pr_count  = 1;
                end
                else
                begin
                    if (pr_crc_lo == pr_fcrc[7:0] && b == pr_fcrc[15:8])
                    begin
                        if (pr_len == 0)
                            queue_result(ST_EMPTY, pr_cmd, pr_seq, '0, '0, '0, 1'b1);
                        else
                            for (int i = 0; i < pr_len && i < 31; i++)
                                queue_result(ST_PAYLOAD, pr_cmd, pr_seq, pr_len[4:0],
                                             pr_store[i % BUF_DEPTH], 5'(i),
                                             (i + 1 == pr_len));
                    end
                    else
                    begin
                        queue_result(ST_FCRC_BAD, pr_cmd, pr_seq, pr_len[4:0], '0, '0, 1'b1);
                    end
                    pr_phase = P_HUNT;
                end
            end
            default:
            begin
                pr_phase = P_HUNT;
                if (b == cfg_start)
                begin
                    pr_hcrc  = crc8_next(cfg_hdr_seed, b);
                    pr_fcrc  = crc16_next(cfg_frame_seed, b);
                    pr_len   = '0;
                    pr_seq   = '0;
                    pr_cmd   = '0;
                    pr_count = 0;
                    pr_phase = P_HDR;
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    // sender: one transfer per accepted byte, prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else
        begin
            if (rx_valid && rx_ready)
                deframe_step(rx_byte);
            if (!rx_valid || rx_ready)
            begin
                if (rx_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= 14))
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= rx_backlog.pop_front();
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result transfer, random back-pressure, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result expected none got status %0d byte %0d",
                             $time, status, payload_byte);
                    err_count++;
                end
                else
                begin
                    seen_want = predicted_results.pop_front();
                    check_field("status", 16'(seen_want.st), 16'(status));
                    check_field("command_id", seen_want.cmd, command_id);
                    check_field("sequence_res", 16'(seen_want.seq), 16'(sequence_res));
                    check_field("payload_length", 16'(seen_want.len), 16'(payload_length));
                    check_field("payload_byte", 16'(seen_want.data), 16'(payload_byte));
                    check_field("byte_index", 16'(seen_want.idx), 16'(byte_index));
                    check_field("last", 16'(seen_want.lst), 16'(last));
                end
            end
            if (stall_ack != stall_req)
            begin
                stall_ack  <= stall_req;
                stall_left <= HOLD_CYCLES;
                res_ready  <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res_ready  <= 1'b0;
            end
            else
            begin
                res_ready <= steady_flow || ($urandom_range(99) >= 14);
            end
        end
    end

    function automatic void push_rx(logic [7:0] b);
        rx_backlog.push_back(b);
        queued_bytes++;
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        push_rx(b);
        gen_hcrc = crc8_next(gen_hcrc, b);
        gen_fcrc = crc16_next(gen_fcrc, b);
    endfunction

    // fill < 0 gives random payload bytes
    task automatic build_frame(frame_kind_t kind, logic [15:0] len, logic [7:0] seq,
                               logic [15:0] cmd, int fill);
        logic [7:0]  hcrc_sent;
        logic [15:0] fcs;
        logic [15:0] fcs_err;
        gen_hcrc = cfg_hdr_seed;
        gen_fcrc = cfg_frame_seed;
        queue_byte(cfg_start);
        queue_byte(len[7:0]);
        queue_byte(len[15:8]);
        if (kind == FR_LEN_BAD)
            return;
        queue_byte(seq);
        hcrc_sent = gen_hcrc;
        if (kind == FR_HDR_BAD)
            hcrc_sent ^= 8'($urandom_range(255, 1));
        queue_byte(hcrc_sent);
        if (kind == FR_HDR_BAD)
            return;
        queue_byte(cmd[7:0]);
        queue_byte(cmd[15:8]);
        for (int i = 0; i < len; i++)
            queue_byte((fill < 0) ? 8'($urandom) : 8'(fill));
        fcs = gen_fcrc;
        if (kind == FR_FCS_BAD)
        begin
            // corrupt low byte, high byte or both
            case ($urandom_range(2))
                0:       fcs_err = {8'h00, 8'($urandom_range(255, 1))};
                1:       fcs_err = {8'($urandom_range(255, 1)), 8'h00};
                default: fcs_err = {8'($urandom_range(255, 1)), 8'($urandom_range(255, 1))};
            endcase
            fcs ^= fcs_err;
        end
        push_rx(fcs[7:0]);
        push_rx(fcs[15:8]);
    endtask

    task automatic random_frame();
        int lim;
        int small_max;
        int pick;
        int r;
        logic [15:0] len;
        lim = (cfg_limit < 32) ? int'(cfg_limit) : 32;
        if (lim > BUF_DEPTH)
            lim = BUF_DEPTH;
        small_max = (lim - 1 < 7) ? lim - 1 : 7;
        pick = $urandom_range(99);
        r = $urandom_range(9);
        if (r < 6)
            len = 16'($urandom_range(small_max));
        else if (r < 8)
            len = 16'(lim - 1);
        else
            len = 16'($urandom_range(lim - 1));
        if (pick < 55)
        begin
            build_frame(FR_GOOD, len, 8'($urandom), 16'($urandom), -1);
        end
        else if (pick < 65)
        begin
            build_frame(FR_HDR_BAD, len, 8'($urandom), 16'($urandom), -1);
        end
        else if (pick < 75)
        begin
            build_frame(FR_FCS_BAD, len, 8'($urandom), 16'($urandom), -1);
        end
        else if (pick < 85)
        begin
            case ($urandom_range(2))
                0:       len = 16'(lim);
                1:       len = 16'($urandom_range(65535, lim));
                default: len = {8'($urandom_range(255, 1)), 8'($urandom)};
            endcase
            build_frame(FR_LEN_BAD, len, '0, '0, -1);
        end
        else
        begin
            // line noise, sometimes a truncated frame
            if ($urandom_range(1))
                push_rx(cfg_start);
            repeat ($urandom_range(3, 1)) push_rx(8'($urandom));
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_BYTE: cfg_start      = data[7:0];
            CFG_LENGTH_LIM: cfg_limit      = data[5:0];
            CFG_HDR_SEED:   cfg_hdr_seed   = data[7:0];
            default:        cfg_frame_seed = data;
        endcase
    endtask

    task automatic drain();
        while (rx_backlog.size() != 0 || rx_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic run_phase(logic [7:0] sb, logic [5:0] lim, logic [7:0] hseed,
                             logic [15:0] fseed, bit hold_off);
        int first;
        write_reg(CFG_START_BYTE, {8'h00, sb});
        write_reg(CFG_LENGTH_LIM, {10'h000, lim});
        write_reg(CFG_HDR_SEED, {8'h00, hseed});
        write_reg(CFG_FRAME_SEED, fseed);
        first = queued_bytes;
        if (hold_off)
        begin
            // receiver blocks while a full-size frame drains, input must back up
            stall_req++;
            build_frame(FR_GOOD, 16'd31, 8'($urandom), 16'($urandom), -1);
        end
        while (queued_bytes - first < PHASE_BYTES)
            random_frame();
        drain();
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset register values
        build_frame(FR_GOOD, 16'd0, START_BYTE_RST, 16'hFFFF, -1);
        build_frame(FR_GOOD, 16'd1, 8'h00, 16'h0000, 8'hFF);
        build_frame(FR_LEN_BAD, 16'hFFFF, '0, '0, -1);
        build_frame(FR_HDR_BAD, 16'd31, 8'hFF, '0, -1);
        build_frame(FR_FCS_BAD, 16'd0, 8'h5A, 16'h1234, -1);
        push_rx(8'h00);
        drain();

        run_phase(8'h00, 6'd1, 8'h00, 16'h0000, 1'b0);
        run_phase(8'hFF, 6'd32, 8'hFF, 16'hFFFF, 1'b1);
        steady_flow = 1'b1;
        run_phase(8'($urandom), 6'($urandom_range(31, 2)), 8'($urandom), 16'($urandom), 1'b0);
        steady_flow = 1'b0;
        run_phase(8'h5A, 6'd17, 8'($urandom), 16'($urandom), 1'b0);
        run_phase(START_BYTE_RST, LENGTH_LIM_RST, HDR_SEED_RST, FRAME_SEED_RST, 1'b0);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
